/* design/lzcd_pkg.sv */
// lzcd_pkg: shared constants, codes and control/status structs of the lz decompressor
`default_nettype none
package lzcd_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
   localparam int LANE_BYTES   = 8;
   localparam int LANE_BITS    = 8 * LANE_BYTES;
   localparam int COUNT_BITS   = 4;
   localparam int LENGTH_BITS  = 30;
   localparam int MATCH_BITS   = 9;
   localparam int OFFSET_BITS  = 12;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 104;
   localparam int RSP_USER_BITS = 3;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 30;

   localparam logic [3:0]            LEN_CODE_EXT   = 4'hf;
   localparam logic [MATCH_BITS-1:0] MIN_MATCH      = 9'd3;
   localparam logic [MATCH_BITS-1:0] EXT_BASE       = 9'd18;
   localparam logic [3:0]            ITEMS_PER_CTRL = 4'd8;

   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_FIRST = 2'd1;
   localparam logic [1:0] PHASE_EXT   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
   localparam logic [1:0] STATUS_BAD_OFFSET = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_RAW_SIZE = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REQUIRE  = 1'b1;

   typedef struct packed {
      logic capture;
      logic decode;
      logic rd_issue;
      logic wr_byte;
      logic load_out;
      logic out_last;
   } lzcd_cmd_type;

   typedef struct packed {
      logic more;
      logic chunk_full;
      logic chunk_nonempty;
      logic fin;
   } lzcd_stat_type;

endpackage
`default_nettype wire

/* design/lzcd_ram.sv */
// lzcd_ram: generic single write port ram with registered read
`default_nettype none
module lzcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

/* design/lzcd_datapath.sv */
// lzcd_datapath: stream state, history ram, chunk assembly and result registers
`default_nettype none
module lzcd_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lzcd_pkg::lzcd_cmd_type               cmd,
   output lzcd_pkg::lzcd_stat_type                   stat,
   input  wire logic [lzcd_pkg::REQ_DATA_BITS-1:0]   in_byte,
   input  wire logic                                 in_final,
   input  wire logic                                 csr_we,
   input  wire logic [lzcd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [lzcd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic [lzcd_pkg::LANE_BITS-1:0]            out_data,
   output logic [lzcd_pkg::COUNT_BITS-1:0]           out_count,
   output logic                                      out_run_last,
   output logic                                      out_stream_done,
   output logic [1:0]                                out_status,
   output logic [lzcd_pkg::LENGTH_BITS-1:0]          out_length
);
   import lzcd_pkg::*;

   logic [LENGTH_BITS-1:0] raw_size_ff, raw_size_in;
   logic                   require_ff, require_in;
   logic [7:0]             ctrl_ff, ctrl_in;
   logic [3:0]             items_ff, items_in;
   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             tag_first_ff, tag_first_in;
   logic [7:0]             tag_second_ff, tag_second_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic [1:0]             err_ff, err_in;
   logic                   extra_ff, extra_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   fin_ff, fin_in;
   logic [MATCH_BITS-1:0]  remain_ff, remain_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [LANE_BITS-1:0]   chunk_ff, chunk_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;

   logic [LANE_BITS-1:0]   odata_ff, odata_in;
   logic [COUNT_BITS-1:0]  ocnt_ff, ocnt_in;
   logic                   olast_ff, olast_in;
   logic                   odone_ff, odone_in;
   logic [1:0]             ostat_ff, ostat_in;
   logic [LENGTH_BITS-1:0] olen_ff, olen_in;

   logic [OFFSET_BITS-1:0] off_now;
   logic [MATCH_BITS-1:0]  len_now;
   logic                   bad_off;
   logic                   append_en;
   logic [7:0]             append_byte;
   logic [7:0]             ram_rdata;
   logic [1:0]             end_status;
   logic                   done_now;

   // offset and length of a tag completing with the current byte
   always_comb begin
      if (phase_ff == PHASE_FIRST) begin
         off_now = {tag_first_ff[7:4], byte_ff};
         len_now = {5'd0, tag_first_ff[3:0]} + MIN_MATCH;
      end else begin
         off_now = {tag_first_ff[7:4], tag_second_ff};
         len_now = EXT_BASE + {1'b0, byte_ff};
      end
      bad_off = (off_now == '0) ||
                ({{(LENGTH_BITS-OFFSET_BITS){1'b0}}, off_now} > total_ff);
   end

   always_comb begin
      if (err_ff != STATUS_OK) begin
         end_status = err_ff;
      end else if (phase_ff != PHASE_NONE) begin
         end_status = STATUS_TRUNCATED;
      end else if (require_ff && ((total_ff != raw_size_ff) || extra_ff)) begin
         end_status = STATUS_MISMATCH;
      end else begin
         end_status = STATUS_OK;
      end
   end

   always_comb begin
      raw_size_in   = raw_size_ff;
      require_in    = require_ff;
      ctrl_in       = ctrl_ff;
      items_in      = items_ff;
      phase_in      = phase_ff;
      tag_first_in  = tag_first_ff;
      tag_second_in = tag_second_ff;
      total_in      = total_ff;
      err_in        = err_ff;
      extra_in      = extra_ff;
      byte_in       = byte_ff;
      fin_in        = fin_ff;
      remain_in     = remain_ff;
      off_in        = off_ff;
      chunk_in      = chunk_ff;
      cnt_in        = cnt_ff;
      odata_in      = odata_ff;
      ocnt_in       = ocnt_ff;
      olast_in      = olast_ff;
      odone_in      = odone_ff;
      ostat_in      = ostat_ff;
      olen_in       = olen_ff;
      append_en     = 1'b0;
      append_byte   = byte_ff;
      done_now      = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            CSR_RAW_SIZE: raw_size_in = csr_wdata;
            CSR_REQUIRE:  require_in  = csr_wdata[0];
            default:      raw_size_in = raw_size_ff;
         endcase
      end

      if (cmd.capture) begin
         byte_in = in_byte;
         fin_in  = in_final;
      end

      if (cmd.decode) begin
         remain_in = '0;
         if (err_ff != STATUS_OK) begin
            err_in = err_ff;
         end else if (total_ff >= raw_size_ff) begin
            extra_in = 1'b1;
         end else if (phase_ff == PHASE_NONE && items_ff == '0) begin
            ctrl_in  = byte_ff;
            items_in = ITEMS_PER_CTRL;
         end else if (phase_ff == PHASE_NONE) begin
            if (ctrl_ff[0]) begin
               tag_first_in = byte_ff;
               phase_in     = PHASE_FIRST;
            end else begin
               append_en = 1'b1;
               ctrl_in   = {1'b0, ctrl_ff[7:1]};
               items_in  = items_ff - 4'd1;
            end
         end else if (phase_ff == PHASE_FIRST && tag_first_ff[3:0] == LEN_CODE_EXT) begin
            tag_second_in = byte_ff;
            phase_in      = PHASE_EXT;
         end else begin
            if (phase_ff == PHASE_FIRST) begin
               tag_second_in = byte_ff;
            end
            phase_in = PHASE_NONE;
            if (bad_off) begin
               err_in = STATUS_BAD_OFFSET;
            end else begin
               remain_in = len_now;
               off_in    = off_now;
               ctrl_in   = {1'b0, ctrl_ff[7:1]};
               items_in  = items_ff - 4'd1;
            end
         end
      end

      if (cmd.wr_byte) begin
         append_en   = 1'b1;
         append_byte = ram_rdata;
         remain_in   = remain_ff - 9'd1;
      end

      if (append_en) begin
         chunk_in[cnt_ff[2:0]*8 +: 8] = append_byte;
         cnt_in   = cnt_ff + 4'd1;
         total_in = total_ff + 30'd1;
      end

      if (cmd.load_out) begin
         done_now = cmd.out_last && fin_ff;
         odata_in = chunk_ff;
         ocnt_in  = cnt_ff;
         olast_in = cmd.out_last;
         odone_in = done_now;
         ostat_in = done_now ? end_status : STATUS_OK;
         olen_in  = total_ff;
         chunk_in = '0;
         cnt_in   = '0;
         if (done_now) begin
            // end of stream: stream state back to its reset values; csr settings are kept
            ctrl_in       = '0;
            items_in      = '0;
            phase_in      = PHASE_NONE;
            tag_first_in  = '0;
            tag_second_in = '0;
            total_in      = '0;
            err_in        = STATUS_OK;
            extra_in      = 1'b0;
            remain_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_size_ff   <= '0;
         require_ff    <= 1'b1;
         ctrl_ff       <= '0;
         items_ff      <= '0;
         phase_ff      <= PHASE_NONE;
         tag_first_ff  <= '0;
         tag_second_ff <= '0;
         total_ff      <= '0;
         err_ff        <= STATUS_OK;
         extra_ff      <= 1'b0;
         remain_ff     <= '0;
         chunk_ff      <= '0;
         cnt_ff        <= '0;
      end else begin
         raw_size_ff   <= raw_size_in;
         require_ff    <= require_in;
         ctrl_ff       <= ctrl_in;
         items_ff      <= items_in;
         phase_ff      <= phase_in;
         tag_first_ff  <= tag_first_in;
         tag_second_ff <= tag_second_in;
         total_ff      <= total_in;
         err_ff        <= err_in;
         extra_ff      <= extra_in;
         remain_ff     <= remain_in;
         chunk_ff      <= chunk_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      fin_ff   <= fin_in;
      off_ff   <= off_in;
      odata_ff <= odata_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
      odone_ff <= odone_in;
      ostat_ff <= ostat_in;
      olen_ff  <= olen_in;
   end

   lzcd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock (clock),
      .we    (append_en),
      .waddr (total_ff[ADDR_BITS-1:0]),
      .wdata (append_byte),
      .re    (cmd.rd_issue),
      .raddr (total_ff[ADDR_BITS-1:0] - off_ff[ADDR_BITS-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      stat.more           = (remain_ff != '0) && (total_ff < raw_size_ff);
      stat.chunk_full     = (cnt_ff == COUNT_BITS'(LANE_BYTES));
      stat.chunk_nonempty = (cnt_ff != '0);
      stat.fin            = fin_ff;
   end

   assign out_data        = odata_ff;
   assign out_count       = ocnt_ff;
   assign out_run_last    = olast_ff;
   assign out_stream_done = odone_ff;
   assign out_status      = ostat_ff;
   assign out_length      = olen_ff;
endmodule
`default_nettype wire

/* design/lzcd_control.sv */
// lzcd_control: sequencer for request intake, match copy and result handoff
`default_nettype none
module lzcd_control (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire lzcd_pkg::lzcd_stat_type stat,
   output lzcd_pkg::lzcd_cmd_type       cmd
);
   import lzcd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_WRITE,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_READ;
         end
         S_READ: begin
            if (stat.chunk_full) begin
               cmd.load_out = 1'b1;
               cmd.out_last = !stat.more;
               last_in      = !stat.more;
               state_in     = S_EMIT;
            end else if (!stat.more) begin
               if (stat.chunk_nonempty || stat.fin) begin
                  cmd.load_out = 1'b1;
                  cmd.out_last = 1'b1;
                  last_in      = 1'b1;
                  state_in     = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.wr_byte = 1'b1;
            state_in    = S_READ;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               state_in = last_ff ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result sides open together");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_byte |-> $past(cmd.rd_issue))
      else $error("history copy without preceding read");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_decode_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.decode)
      else $error("accepted request not decoded");
endmodule
`default_nettype wire

/* design/lz_control_byte_decompressor.sv */
// lz_control_byte_decompressor: top level of the control-byte lz stream decompressor
//
// usage
//   req channel: one compressed byte per request in req_tdata, req_tlast on the
//   last byte of a stream. rsp channel: chunks of up to eight decompressed bytes
//   with count and running length, rsp_tlast on the last chunk caused by a
//   request, rsp_tuser carrying end-of-stream flag and status.
//   csr port: write raw_size (index 0) and require_complete (index 1) between
//   streams, single cycle, no read back.
// sequence
//   a control byte or tag byte passes capture, decode and a check state; a literal
//   passes the same states plus result handoff; a match copies each byte as a history
//   ram read then write (registered read port), plus one handoff per 8-byte chunk.
//   one request is in flight at a time.
// reset
//   synchronous, clears the stream state, raw_size to 0, require_complete to 1;
//   the history ram is not cleared and is only read at written locations.
// backpressure
//   while rsp_tready is low the current chunk is held and no request is taken.
`default_nettype none
module lz_control_byte_decompressor (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request side
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [lzcd_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // in_byte
   input  wire logic                                 req_tlast,  // in_final
   // result side
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // out_data[63:0], out_count[67:64], produced_length[97:68], zero fill
   output logic [lzcd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   output logic                                      rsp_tlast,  // run_last
   // stream_done[0], status[2:1]
   output logic [lzcd_pkg::RSP_USER_BITS-1:0]        rsp_tuser,
   // register writes
   input  wire logic                                 csr_we,
   input  wire logic [lzcd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [lzcd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lzcd_pkg::*;

   lzcd_cmd_type           cmd;
   lzcd_stat_type          stat;
   logic [LANE_BITS-1:0]   out_data;
   logic [COUNT_BITS-1:0]  out_count;
   logic                   out_run_last;
   logic                   out_stream_done;
   logic [1:0]             out_status;
   logic [LENGTH_BITS-1:0] out_length;

   // sequencer: intake, decode, copy loop, result handoff
   lzcd_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // stream state, history window and result registers
   lzcd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_byte         (req_tdata),
      .in_final        (req_tlast),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .out_data        (out_data),
      .out_count       (out_count),
      .out_run_last    (out_run_last),
      .out_stream_done (out_stream_done),
      .out_status      (out_status),
      .out_length      (out_length)
   );

   // pack result fields, lowest field first, zero fill to a byte boundary
   assign rsp_tdata = {{(RSP_DATA_BITS-LANE_BITS-COUNT_BITS-LENGTH_BITS){1'b0}},
                       out_length, out_count, out_data};
   assign rsp_tlast = out_run_last;
   assign rsp_tuser = {out_status, out_stream_done};
endmodule
`default_nettype wire
